/* sv/drrip_pkg.sv */
// shared types and constants for the drrip stream-aware replacement unit
// no dependencies; imported by drrip_stream_aware_replacement_unit
package drrip_pkg;

    // control states, one-hot
    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_CALC  = 3'b100
    } t_state;

    typedef logic [1:0] t_rrpv;

    localparam t_rrpv RRPV_HIT  = 2'd0;
    localparam t_rrpv RRPV_NEAR = 2'd2;
    localparam t_rrpv RRPV_MAX  = 2'd3;

    localparam logic [1:0] STRIDE_CNT_MAX   = 2'd3;
    localparam logic [1:0] STREAM_THR_RESET = 2'd3;

    localparam int STRIDE_SHORT = 64;
    localparam int STRIDE_LONG  = 128;

    // stream word layout (bits from the lowest up)
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 8;
    localparam int IN_ADDR_W  = 48;
    localparam int IN_SET_W   = 11;
    localparam int IN_WAY_W   = 4;
    localparam int IN_RND_W   = 5;

endpackage

/* sv/drrip_stream_aware_replacement_unit.sv */
// drrip replacement unit with 2-bit rrpv per way and per-set stride detection
// depends on drrip_pkg (types, state codes, word layout constants)
//
// channel | dir | handshake                     | contents
// --------+-----+-------------------------------+-----------------------------------------
// s       | in  | i_s_tvalid / o_s_tready       | tdata: set_index, address, hit_way,
//         |     |                               | random_bits; tuser: hit
// m       | out | o_m_tvalid / i_m_tready       | tdata: chosen_way, written_rrpv,
//         |     |                               | streaming, used_bimodal
// cfg     | in  | i_cfg_we (no wait)            | i_cfg_wdata: streaming threshold
//
// each word is handled in order: the synchronous read of the set's rrpv row and stride entry
// on accept, then in S_CALC the compute, the row write-back and the output register load
// after reset a clearing pass over all NUM_SETS sets fills both memories; no word is taken then
// a word is taken only when the output register is empty or drains at the same edge
// so a stalled result holds o_s_tready low until it is read
module drrip_stream_aware_replacement_unit
    import drrip_pkg::*;
#(
    parameter int NUM_SETS     = 2048,
    parameter int NUM_WAYS     = 16,
    parameter int LEADER_SETS  = 64,
    parameter int SELECTOR_MAX = 1023,
    parameter int ADDR_WIDTH   = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_wdata,   // streaming threshold
    // access words
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [10:0] set_index, [58:11] address, [62:59] hit_way, [67:63] random_bits, [71:68] zero
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,     // [0] hit
    // result words
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [3:0] chosen_way, [5:4] written_rrpv, [6] streaming, [7] used_bimodal
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    // derived sizes
    localparam int SW    = $clog2(NUM_SETS);
    localparam int WW    = $clog2(NUM_WAYS);
    localparam int AW    = (ADDR_WIDTH < IN_ADDR_W) ? ADDR_WIDTH : IN_ADDR_W;
    localparam int DW    = AW + 1;
    localparam int ROW_W = 2 * NUM_WAYS;
    localparam int STR_W = AW + 3;               // {valid, counter, address}
    localparam int SEL_W = $clog2(SELECTOR_MAX + 1);

    localparam logic [SW-1:0]    LEAD_LO  = SW'(LEADER_SETS);
    localparam logic [SW-1:0]    BRRIP_LO = SW'(NUM_SETS - LEADER_SETS);
    localparam logic [SW-1:0]    LAST_SET = SW'(NUM_SETS - 1);
    localparam logic [SEL_W-1:0] SEL_MAX  = SEL_W'(SELECTOR_MAX);
    localparam logic [SEL_W-1:0] SEL_MID  = SEL_W'(SELECTOR_MAX / 2);
    localparam logic [DW-1:0]    D_SHORT  = DW'(STRIDE_SHORT);
    localparam logic [DW-1:0]    D_LONG   = DW'(STRIDE_LONG);

    // input field positions
    localparam int P_ADDR = IN_SET_W;
    localparam int P_WAY  = P_ADDR + IN_ADDR_W;
    localparam int P_RND  = P_WAY + IN_WAY_W;

    // state memories
    logic [ROW_W-1:0] rrpv_mem  [NUM_SETS];
    logic [STR_W-1:0] strd_mem  [NUM_SETS];
    logic [ROW_W-1:0] r_rrpv_q;
    logic [STR_W-1:0] r_strd_q;

    t_state           r_state, n_state;
    logic [SW-1:0]    r_clr;
    logic [SEL_W-1:0] r_sel, n_sel;
    logic [1:0]       r_thr;

    // captured access
    logic [SW-1:0]       r_set;
    logic [AW-1:0]       r_addr;
    logic                r_hit;
    logic [WW-1:0]       r_way;
    logic [IN_RND_W-1:0] r_rnd;

    // output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic          accept;
    logic [SW-1:0] in_set;
    logic [WW-1:0] in_way;
    logic [16:0]   set_red;
    logic [8:0]    way_red;

    // set index and way folded into range by a few conditional subtracts
    always_comb begin
        set_red = 17'(i_s_tdata[IN_SET_W-1:0]);
        for (int k = 3; k >= 0; k--) begin
            if (set_red >= 17'(NUM_SETS << k)) begin
                set_red = set_red - 17'(NUM_SETS << k);
            end
        end
        way_red = 9'(i_s_tdata[P_WAY +: IN_WAY_W]);
        for (int k = 3; k >= 0; k--) begin
            if (way_red >= 9'(NUM_WAYS << k)) begin
                way_red = way_red - 9'(NUM_WAYS << k);
            end
        end
        in_set = set_red[SW-1:0];
        in_way = way_red[WW-1:0];
    end

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;

    // compute stage
    logic              srrip_lead, brrip_lead, bimodal, streaming, step;
    logic [AW:0]       diff;
    logic [1:0]        cnt_old, cnt_new;
    t_rrpv             ins, wr;
    t_rrpv             rv    [NUM_WAYS];
    t_rrpv             top, age;
    logic              any3, any2, any1;
    logic [WW-1:0]     victim, way;
    logic [ROW_W-1:0]  row_new;
    logic [STR_W-1:0]  strd_new;

    always_comb begin
        srrip_lead = r_set < LEAD_LO;
        brrip_lead = !srrip_lead && (r_set >= BRRIP_LO);

        // stride detector: distance of 64 or 128 bytes either way
        // one extra bit keeps the sign so a wrap across zero is no stride
        cnt_old = r_strd_q[AW +: 2];
        diff    = {1'b0, r_addr} - {1'b0, r_strd_q[AW-1:0]};
        step    = r_strd_q[AW + 2] &&
                  (diff == D_SHORT || diff == D_LONG ||
                   diff == (~D_SHORT + 1'b1) || diff == (~D_LONG + 1'b1));
        if (step) begin
            cnt_new = (cnt_old == STRIDE_CNT_MAX) ? cnt_old : cnt_old + 2'd1;
        end else begin
            cnt_new = (cnt_old == 2'd0) ? cnt_old : cnt_old - 2'd1;
        end
        strd_new  = {1'b1, cnt_new, r_addr};
        streaming = cnt_new >= r_thr;

        priority if (srrip_lead) begin
            bimodal = 1'b0;
        end else if (brrip_lead) begin
            bimodal = 1'b1;
        end else begin
            bimodal = r_sel < SEL_MID;
        end
        ins = (bimodal && r_rnd != '0) ? RRPV_MAX : RRPV_NEAR;
        if (streaming) begin
            ins = RRPV_MAX;
        end

        // victim: first way at the set's highest rrpv; on a miss the other ways are aged by 3 - top
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            rv[w] = r_rrpv_q[2*w +: 2];
            any3  = any3 | (rv[w] == 2'd3);
            any2  = any2 | (rv[w] == 2'd2);
            any1  = any1 | (rv[w] == 2'd1);
        end
        top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
        age = RRPV_MAX - top;
        victim = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (rv[w] == top) begin
                victim = WW'(w);
            end
        end

        way = r_hit ? r_way : victim;
        wr  = r_hit ? RRPV_HIT : ins;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (WW'(w) == way) begin
                row_new[2*w +: 2] = wr;
            end else if (r_hit) begin
                row_new[2*w +: 2] = rv[w];
            end else begin
                row_new[2*w +: 2] = rv[w] + age;
            end
        end

        // set dueling counter
        n_sel = r_sel;
        if (!r_hit) begin
            if (srrip_lead && r_sel != '0) begin
                n_sel = r_sel - 1'b1;
            end else if (brrip_lead && r_sel != SEL_MAX) begin
                n_sel = r_sel + 1'b1;
            end
        end

        n_out_data = {bimodal, streaming, wr, 4'(way)};
    end

    // next control state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_SET) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // memories: one read on accept, one write per clearing step or compute cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rrpv_q <= rrpv_mem[in_set];
            r_strd_q <= strd_mem[in_set];
        end
        if (r_state == S_CLEAR) begin
            rrpv_mem[r_clr] <= {NUM_WAYS{RRPV_MAX}};
            strd_mem[r_clr] <= '0;
        end else if (r_state == S_CALC) begin
            rrpv_mem[r_set] <= row_new;
            strd_mem[r_set] <= strd_new;
        end
    end

    // captured access and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set  <= in_set;
            r_addr <= i_s_tdata[P_ADDR +: AW];
            r_hit  <= i_s_tuser;
            r_way  <= in_way;
            r_rnd  <= i_s_tdata[P_RND +: IN_RND_W];
        end
        if (r_state == S_CALC) begin
            r_out_data <= n_out_data;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_sel       <= SEL_MID;
            r_thr       <= STREAM_THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_CALC) begin
                r_sel       <= n_sel;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for drrip_stream_aware_replacement_unit: directed and random accesses,
// each result word checked against an in-bench drrip predictor kept in a scoreboard class
// depends on drrip_pkg and the unit's rtl only
module testbench;
    import drrip_pkg::*;

    // geometry of the unit as instantiated (its default parameters)
    localparam int SETS      = 2048;
    localparam int WAYS      = 16;
    localparam int LEADERS   = 64;
    localparam int SEL_LIMIT = 1023;

    // one access word as seen on the slave side
    typedef struct packed {
        logic [10:0] set_idx;
        logic [47:0] addr;
        logic        hit;
        logic [3:0]  way;
        logic [4:0]  rnd;
    } t_access;

    // one expected result word
    typedef struct packed {
        logic [3:0] way;
        t_rrpv      rrpv;
        logic       streaming;
        logic       bimodal;
    } t_choice;

    // which leader group a random segment hammers, steering the selector down or up
    typedef enum logic {
        FOCUS_SRRIP_LEAD,
        FOCUS_BRRIP_LEAD
    } t_focus;

    // tracks the replacement state of the whole cache and the words it must produce
    class replacement_scoreboard;
        t_rrpv       rrpv_row   [SETS][WAYS];
        logic [47:0] prior_addr [SETS];
        bit          last_valid [SETS];
        logic [1:0]  stride_cnt [SETS];
        logic [9:0]  psel;
        logic [1:0]  threshold;
        t_choice     expected_choices [$];
        int          errors;

        function new();
            foreach (rrpv_row[s, w]) rrpv_row[s][w] = RRPV_MAX;
            foreach (prior_addr[s]) begin
                prior_addr[s] = '0;
                last_valid[s] = 1'b0;
                stride_cnt[s] = '0;
            end
            psel      = 10'(SEL_LIMIT / 2);
            threshold = STREAM_THR_RESET;
            errors    = 0;
        endfunction

        function void set_threshold(logic [1:0] value);
            threshold = value;
        endfunction

        function int outstanding();
            return expected_choices.size();
        endfunction

        // works out the word an accepted access must produce and updates the cache state
        function void note_access(t_access a);
            int unsigned s;
            logic [47:0] delta;
            bit          stride_seen;
            bit          srrip_lead;
            bit          brrip_lead;
            t_rrpv       fill;
            t_rrpv       top;
            int          victim;
            t_choice     want;
            s = a.set_idx;
            // stride detector runs first, on hits and misses alike
            stride_seen = 1'b0;
            if (last_valid[s]) begin
                delta = (a.addr > prior_addr[s]) ? a.addr - prior_addr[s]
                                                 : prior_addr[s] - a.addr;
                stride_seen = (delta == 48'(STRIDE_SHORT)) || (delta == 48'(STRIDE_LONG));
            end
            if (stride_seen) begin
                if (stride_cnt[s] != STRIDE_CNT_MAX) stride_cnt[s]++;
            end else if (stride_cnt[s] != 2'd0) begin
                stride_cnt[s]--;
            end
            prior_addr[s] = a.addr;
            last_valid[s] = 1'b1;
            // policy: leaders are fixed, followers go by the selector
            srrip_lead   = s < LEADERS;
            brrip_lead   = !srrip_lead && s >= SETS - LEADERS;
            want.bimodal = srrip_lead ? 1'b0 : brrip_lead ? 1'b1 : (psel < SEL_LIMIT / 2);
            fill = (want.bimodal && a.rnd != 5'd0) ? RRPV_MAX : RRPV_NEAR;
            want.streaming = stride_cnt[s] >= threshold;
            if (want.streaming) fill = RRPV_MAX;
            if (a.hit) begin
                want.way  = a.way;
                want.rrpv = RRPV_HIT;
            end else begin
                // age the whole set so that its oldest way reaches the distant value
                top = RRPV_HIT;
                for (int w = 0; w < WAYS; w++)
                    if (rrpv_row[s][w] > top) top = rrpv_row[s][w];
                if (top != RRPV_MAX)
                    for (int w = 0; w < WAYS; w++)
                        rrpv_row[s][w] = rrpv_row[s][w] + (RRPV_MAX - top);
                victim = -1;
                for (int w = 0; w < WAYS; w++)
                    if (victim < 0 && rrpv_row[s][w] == RRPV_MAX) victim = w;
                want.way  = victim[3:0];
                want.rrpv = fill;
                if (srrip_lead) begin
                    if (psel != 10'd0) psel--;
                end else if (brrip_lead && psel != 10'(SEL_LIMIT)) begin
                    psel++;
                end
            end
            rrpv_row[s][want.way] = want.rrpv;
            expected_choices.push_back(want);
        endfunction

        task report(string what, int got, int want);
            errors++;
            $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
        endtask

        task check_result(logic [OUT_DATA_W-1:0] word);
            t_choice want;
            if (expected_choices.size() == 0) begin
                report("result word with nothing pending", word, -1);
                return;
            end
            want = expected_choices.pop_front();
            if (word[3:0] != want.way)       report("chosen_way", word[3:0], want.way);
            if (word[5:4] != want.rrpv)      report("written_rrpv", word[5:4], want.rrpv);
            if (word[6] != want.streaming)   report("streaming", word[6], want.streaming);
            if (word[7] != want.bimodal)     report("used_bimodal", word[7], want.bimodal);
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_wdata;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;      // set_index, address, hit_way, random_bits, zero pad
    logic                  i_s_tuser;      // hit
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;      // chosen_way, written_rrpv, streaming, used_bimodal

    replacement_scoreboard sb;

    // idle percentages for the current phase
    int gap_pct;
    int stall_pct;

    // generator-side memory: where each set's address walk stands and its next hit way
    bit [47:0] walk_addr [SETS];
    bit [3:0]  walk_way  [SETS];

    // stream threshold per random segment, extremes included
    logic [1:0] threshold_plan [10] = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd1,
                                        2'd2, 2'd3, 2'd0, 2'd2, 2'd1};

    drrip_stream_aware_replacement_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run (clearing pass plus every word fully stalled)
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: random stalls at the current phase's rate
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor: values read here are the ones present just before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.set_threshold(i_cfg_wdata);
            if (i_s_tvalid && o_s_tready)
                sb.note_access('{set_idx: i_s_tdata[10:0], addr: i_s_tdata[58:11],
                                 hit: i_s_tuser, way: i_s_tdata[62:59],
                                 rnd: i_s_tdata[67:63]});
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
        end
    end

    // presents one access word, with a random gap before it, and returns at its acceptance edge
    task automatic send_access(input logic [10:0] set_idx, input logic [47:0] addr,
                               input logic hit, input logic [3:0] way,
                               input logic [4:0] rnd);
        while ($urandom_range(99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, rnd, way, addr, set_idx};
        i_s_tuser  <= hit;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // sender holds off until every pending word has come back, then lets the pipe settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // a run of accesses concentrated on a few leader sets of one kind: mostly address
    // walks of 64 or 128 bytes with round-robin hits, plus near misses and noise
    task automatic run_segment(input t_focus focus, input int hit_pct, input int count);
        logic [10:0] pool [6];
        logic [10:0] set_idx;
        logic [63:0] noise;
        logic [47:0] addr;
        logic [47:0] stride;
        logic [3:0]  way;
        logic [4:0]  rnd;
        logic        hit;
        int          pick;
        foreach (pool[k])
            pool[k] = (focus == FOCUS_SRRIP_LEAD) ? 11'($urandom_range(LEADERS - 1))
                                                  : 11'($urandom_range(SETS - 1, SETS - LEADERS));
        repeat (count) begin
            set_idx = ($urandom_range(99) < 5) ? 11'($urandom_range(SETS - 1))
                                               : pool[$urandom_range(5)];
            noise  = {$urandom, $urandom};
            stride = $urandom_range(1) ? 48'd64 : 48'd128;
            pick   = $urandom_range(99);
            if (pick < 60)
                addr = ($urandom_range(3) == 0) ? walk_addr[set_idx] - stride
                                                : walk_addr[set_idx] + stride;
            else if (pick < 72)
                addr = walk_addr[set_idx] + 48'($urandom_range(255));
            else
                addr = noise[47:0];
            walk_addr[set_idx] = addr;
            hit = ($urandom_range(99) < hit_pct);
            if ($urandom_range(9) < 7) begin
                way = walk_way[set_idx];
                if (hit) walk_way[set_idx] = walk_way[set_idx] + 4'd1;
            end else begin
                way = 4'($urandom_range(15));
            end
            rnd = ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom_range(31));
            send_access(set_idx, addr, hit, way, rnd);
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 2'd0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= 1'b0;
        gap_pct   = 20;
        stall_pct = 85;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset threshold of 3; the first word waits out the clearing pass
        // srrip leader miss at address zero, then brrip leader misses at and just below the top address
        send_access(11'd0,    48'h0,               1'b0, 4'd0,  5'd0);
        send_access(11'd2047, 48'hFFFF_FFFF_FFFF,  1'b0, 4'd15, 5'd31);
        send_access(11'd2047, 48'hFFFF_FFFF_FFBF,  1'b0, 4'd0,  5'd0);
        // stride walk in set 0 up to a streaming miss, then a broken stride
        send_access(11'd0,    48'h40,              1'b1, 4'd15, 5'd0);
        send_access(11'd0,    48'hC0,              1'b1, 4'd0,  5'd31);
        send_access(11'd0,    48'h100,             1'b0, 4'd0,  5'd7);
        send_access(11'd0,    48'h1000,            1'b0, 4'd0,  5'd0);
        // followers while the selector sits just below its midpoint
        send_access(11'd1000, 48'h1234_5678,       1'b0, 4'd0,  5'd5);
        send_access(11'd64,   48'h10,              1'b0, 4'd0,  5'd0);
        // brrip leader walks down to streaming: distant fill, still reported bimodal
        send_access(11'd2047, 48'hFFFF_FFFF_FF3F,  1'b0, 4'd0,  5'd0);
        send_access(11'd2047, 48'hFFFF_FFFF_FEFF,  1'b0, 4'd0,  5'd0);
        // last follower with the selector at or above the midpoint
        send_access(11'd1983, 48'h8000,            1'b0, 4'd0,  5'd0);
        // leader boundaries, hits and misses
        send_access(11'd1984, 48'h0,               1'b1, 4'd7,  5'd0);
        send_access(11'd63,   48'h7777,            1'b1, 4'd8,  5'd1);
        send_access(11'd63,   48'h7777,            1'b0, 4'd8,  5'd1);
        send_access(11'd1983, 48'h8040,            1'b0, 4'd0,  5'd31);
        // repeated address counts as no stride
        send_access(11'd2047, 48'hFFFF_FFFF_FEFF,  1'b1, 4'd3,  5'd0);
        // addresses 64 apart only across the wrap of the address space are no stride
        send_access(11'd5,    48'hFFFF_FFFF_FFF0,  1'b0, 4'd0,  5'd3);
        send_access(11'd5,    48'h30,              1'b0, 4'd0,  5'd3);
        // alternating bit patterns on every field
        send_access(11'd1365, 48'hAAAA_AAAA_AAAA,  1'b0, 4'd10, 5'd10);
        send_access(11'd682,  48'h5555_5555_5555,  1'b1, 4'd5,  5'd21);

        // random part: selector driven down to saturation, then back up; threshold
        // rewritten before each segment once everything pending has come back
        for (int seg = 0; seg < 10; seg++) begin
            drain();
            write_threshold(threshold_plan[seg]);
            gap_pct   = (seg < 4) ? 20 : (seg < 7) ? 85 : 0;
            stall_pct = (seg < 4) ? 85 : (seg < 7) ? 20 : 0;
            run_segment((seg < 6) ? FOCUS_SRRIP_LEAD : FOCUS_BRRIP_LEAD,
                        (seg == 2 || seg == 7) ? 60 : 10, 120);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/drrip_pkg.sv
sv/drrip_stream_aware_replacement_unit.sv
tb/sv/testbench.sv
